// File: rtl/tlbpt_pkg.sv
// Package for the TLB page table translator.
// Holds the shared stamp width and the sequencer state codes; no dependencies.
package tlbpt_pkg;
    localparam int STAMP_W = 32;
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_TLB    = 4'd1;
    localparam logic [3:0] S_PT     = 4'd2;
    localparam logic [3:0] S_PTW    = 4'd3;
    localparam logic [3:0] S_SCAN   = 4'd4;
    localparam logic [3:0] S_OWN    = 4'd5;
    localparam logic [3:0] S_OWNW   = 4'd6;
    localparam logic [3:0] S_EVPV   = 4'd7;
    localparam logic [3:0] S_FILL   = 4'd8;
    localparam logic [3:0] S_STAMP  = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;
    localparam logic [3:0] S_TWAIT  = 4'd11;
endpackage

// File: rtl/tlbpt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/tlbpt_tlb.sv
// TLB slot array: valid bits, tags, frames and use stamps in flip-flops,
// with a fully associative lookup and a one-slot-per-cycle oldest-stamp walk.
// Depends on tlbpt_pkg.
module tlbpt_tlb #(
    parameter int SLOTS = 16,
    parameter int PW    = 8,
    parameter int FW    = 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [PW-1:0]            i_page,
    input  logic                     i_inval,
    input  logic [PW-1:0]            i_inval_page,
    input  logic                     i_fill,
    input  logic [FW-1:0]            i_fill_frame,
    input  logic                     i_stamp,
    input  logic [$clog2(SLOTS)-1:0] i_stamp_slot,
    input  logic [tlbpt_pkg::STAMP_W-1:0] i_stamp_val,
    input  logic                     i_scan,
    output logic                     o_scan_busy,
    output logic                     o_hit,
    output logic [$clog2(SLOTS)-1:0] o_hit_slot,
    output logic [FW-1:0]            o_hit_frame,
    output logic [$clog2(SLOTS)-1:0] o_victim
);
    import tlbpt_pkg::*;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [SLOTS-1:0]   r_valid;
    logic [PW-1:0]      r_tag   [SLOTS];
    logic [FW-1:0]      r_frame [SLOTS];
    logic [STAMP_W-1:0] r_use   [SLOTS];
    logic [SW-1:0]      r_tidx;
    logic [SW-1:0]      r_old;
    logic [STAMP_W-1:0] r_old_use;
    logic               r_tbusy;

    always_comb begin
        o_hit       = 1'b0;
        o_hit_slot  = '0;
        o_hit_frame = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_valid[s] && r_tag[s] == i_page) begin
                o_hit       = 1'b1;
                o_hit_slot  = SW'(s);
                o_hit_frame = r_frame[s];
            end
        end
    end

    // Victim: lowest free slot, else the oldest stamp found by the walk.
    always_comb begin
        logic found;
        found    = 1'b0;
        o_victim = r_old;
        for (int s = 0; s < SLOTS; s++) begin
            if (!found && !r_valid[s]) begin
                found    = 1'b1;
                o_victim = SW'(s);
            end
        end
    end

    assign o_scan_busy = r_tbusy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_tbusy <= 1'b0;
        end else begin
            if (i_inval) begin
                for (int s = 0; s < SLOTS; s++) begin
                    if (r_tag[s] == i_inval_page) r_valid[s] <= 1'b0;
                end
            end
            if (i_fill) r_valid[o_victim] <= 1'b1;
            if (i_scan) begin
                r_tbusy <= (SLOTS > 1);
            end else if (r_tbusy && r_tidx == SW'(SLOTS - 1)) begin
                r_tbusy <= 1'b0;
            end
        end
        // Walk one slot per cycle; strict compare keeps the lowest index on ties.
        if (i_scan) begin
            r_tidx    <= SW'(1);
            r_old     <= '0;
            r_old_use <= r_use[0];
        end else if (r_tbusy) begin
            if (r_use[r_tidx] < r_old_use) begin
                r_old     <= r_tidx;
                r_old_use <= r_use[r_tidx];
            end
            r_tidx <= r_tidx + 1'b1;
        end
        if (i_fill) begin
            r_tag[o_victim]   <= i_page;
            r_frame[o_victim] <= i_fill_frame;
        end
        if (i_stamp) r_use[i_stamp_slot] <= i_stamp_val;
    end
endmodule

// File: rtl/tlb_page_table_translator.sv
// TLB page table translator: 16-slot TLB before a page table in synchronous RAM,
// demand frame allocation, LRU eviction by a one-frame-per-cycle stamp scan.
// A TLB hit goes straight to the stamp update; a TLB miss or free-frame fault waits for
// the oldest-slot walk, and an eviction first scans the stamps of all PHYSICAL_FRAMES.
// One item at a time (busy high); the next may start in the result cycle. Result
// shows one cycle on o_valid, no stall. Sync reset clears valid bits and counters.
module tlb_page_table_translator #(
    parameter int TLB_SLOTS       = 16,
    parameter int VIRTUAL_PAGES   = 256,
    parameter int PHYSICAL_FRAMES = 128,
    parameter int OFFSET_BITS     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_logical_address,
    output logic        o_valid,
    output logic [14:0] o_physical_address,
    output logic        o_tlb_hit,
    output logic        o_page_fault,
    output logic        o_evicted,
    output logic [7:0]  o_evicted_page
);
    import tlbpt_pkg::*;

    localparam int PW  = (VIRTUAL_PAGES > 1) ? $clog2(VIRTUAL_PAGES) : 1;
    localparam int FW  = (PHYSICAL_FRAMES > 1) ? $clog2(PHYSICAL_FRAMES) : 1;
    localparam int FCW = $clog2(PHYSICAL_FRAMES + 1);
    localparam int SW  = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
    localparam int PAW = FW + OFFSET_BITS;

    logic [3:0]   r_state, n_state;
    logic [OFFSET_BITS-1:0] r_off;
    logic [PW-1:0] r_page;
    logic [STAMP_W-1:0] r_refcnt;
    logic [FCW-1:0] r_handed;
    logic [VIRTUAL_PAGES-1:0] r_pvalid;
    logic [FW-1:0] r_frame;
    logic [SW-1:0] r_slot;
    logic          r_hit, r_fault, r_ev;
    logic [PW-1:0] r_evpage;
    logic [FCW-1:0] r_scan;
    logic [FW-1:0] r_best;
    logic [STAMP_W-1:0] r_best_use;
    logic          r_scan_rd;

    // page table frame RAM
    logic          pf_we;
    logic [FW-1:0] pf_rdata;
    // frame owner RAM
    logic          fo_we;
    logic [PW-1:0] fo_rdata;
    // frame stamp RAM
    logic          fu_we;
    logic [FW-1:0] fu_waddr, fu_raddr;
    logic [STAMP_W-1:0] fu_rdata;

    logic          t_hit, t_fill, t_inval, t_stamp;
    logic          t_scan, t_scan_busy;
    logic [SW-1:0] t_hit_slot, t_victim;
    logic [FW-1:0] t_hit_frame;

    logic [15:0] addr_pg;
    assign addr_pg = i_logical_address >> OFFSET_BITS;

    tlbpt_ram #(.WIDTH(FW), .DEPTH(VIRTUAL_PAGES)) u_pframe (
        .i_clk, .i_we(pf_we), .i_waddr(r_page), .i_wdata(r_frame),
        .i_raddr(r_page), .o_rdata(pf_rdata));

    tlbpt_ram #(.WIDTH(PW), .DEPTH(PHYSICAL_FRAMES)) u_owner (
        .i_clk, .i_we(fo_we), .i_waddr(r_frame), .i_wdata(r_page),
        .i_raddr(r_frame), .o_rdata(fo_rdata));

    tlbpt_ram #(.WIDTH(STAMP_W), .DEPTH(PHYSICAL_FRAMES)) u_fuse (
        .i_clk, .i_we(fu_we), .i_waddr(fu_waddr), .i_wdata(r_refcnt),
        .i_raddr(fu_raddr), .o_rdata(fu_rdata));

    tlbpt_tlb #(.SLOTS(TLB_SLOTS), .PW(PW), .FW(FW)) u_tlb (
        .i_clk, .i_rst_n, .i_page(r_page),
        .i_inval(t_inval), .i_inval_page(fo_rdata),
        .i_fill(t_fill), .i_fill_frame(r_frame),
        .i_stamp(t_stamp), .i_stamp_slot(r_slot), .i_stamp_val(r_refcnt),
        .i_scan(t_scan), .o_scan_busy(t_scan_busy),
        .o_hit(t_hit), .o_hit_slot(t_hit_slot), .o_hit_frame(t_hit_frame),
        .o_victim(t_victim));

    assign busy     = (r_state != S_IDLE);
    assign pf_we    = (r_state == S_FILL) && r_fault;
    assign fo_we    = (r_state == S_FILL) && r_fault;
    assign t_inval  = (r_state == S_EVPV);
    assign t_fill   = (r_state == S_FILL);
    assign t_stamp  = (r_state == S_STAMP);
    // Start the oldest-slot walk as soon as the TLB misses.
    assign t_scan   = (r_state == S_TLB) && !t_hit;
    assign fu_we    = (r_state == S_STAMP);
    assign fu_waddr = r_frame;
    // Scan reads frame r_scan; data comes back next cycle.
    assign fu_raddr = r_scan[FW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_TLB;
            S_TLB:   n_state = t_hit ? S_STAMP : S_PT;
            S_PT:    n_state = S_PTW;
            S_PTW: begin
                if (r_pvalid[r_page]) n_state = S_TWAIT;
                else if (r_handed < FCW'(PHYSICAL_FRAMES)) n_state = S_TWAIT;
                else n_state = S_SCAN;
            end
            S_SCAN:  if (r_scan_rd && r_scan == FCW'(PHYSICAL_FRAMES)) n_state = S_OWN;
            S_OWN:   n_state = S_OWNW;
            S_OWNW:  n_state = S_EVPV;
            S_EVPV:  n_state = S_TWAIT;
            // Hold until the oldest-slot walk has finished.
            S_TWAIT: if (!t_scan_busy) n_state = S_FILL;
            S_FILL:  n_state = S_STAMP;
            S_STAMP: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_refcnt <= '0;
            r_handed <= '0;
            r_pvalid <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_DONE);
            if (r_state == S_DONE) r_refcnt <= r_refcnt + 1'b1;
            if (r_state == S_PTW && !r_pvalid[r_page]
                && r_handed < FCW'(PHYSICAL_FRAMES)) begin
                r_handed <= r_handed + 1'b1;
            end
            // Drop the victim page's residency, then mark the new page.
            if (r_state == S_EVPV) r_pvalid[fo_rdata] <= 1'b0;
            if (r_state == S_FILL && r_fault) r_pvalid[r_page] <= 1'b1;
        end

        case (r_state)
            S_IDLE: if (start) begin
                r_off    <= i_logical_address[OFFSET_BITS-1:0];
                r_page   <= addr_pg[PW-1:0];
                r_hit    <= 1'b0;
                r_fault  <= 1'b0;
                r_ev     <= 1'b0;
                r_evpage <= '0;
            end
            S_TLB: if (t_hit) begin
                r_hit   <= 1'b1;
                r_slot  <= t_hit_slot;
                r_frame <= t_hit_frame;
            end
            S_PTW: begin
                r_scan    <= '0;
                r_scan_rd <= 1'b0;
                if (r_pvalid[r_page]) begin
                    r_frame <= pf_rdata;
                end else begin
                    r_fault <= 1'b1;
                    if (r_handed < FCW'(PHYSICAL_FRAMES)) r_frame <= r_handed[FW-1:0];
                end
            end
            S_SCAN: begin
                // Fold in frame r_scan - 1, read last cycle; strict compare keeps the lowest.
                if (r_scan_rd) begin
                    if (r_scan == FCW'(1) || fu_rdata < r_best_use) begin
                        r_best_use <= fu_rdata;
                        r_best     <= FW'(r_scan - 1'b1);
                    end
                end
                if (r_scan != FCW'(PHYSICAL_FRAMES)) r_scan <= r_scan + 1'b1;
                r_scan_rd <= 1'b1;
            end
            S_OWN: r_frame <= r_best;
            S_EVPV: begin
                r_ev     <= 1'b1;
                r_evpage <= fo_rdata;
            end
            S_FILL: r_slot <= t_victim;
            default: ;
        endcase
    end

    logic [PAW-1:0] pa;
    assign pa = {r_frame, r_off};
    assign o_physical_address = 15'(pa);
    assign o_tlb_hit    = r_hit;
    assign o_page_fault = r_fault;
    assign o_evicted    = r_ev;
    assign o_evicted_page = 8'(r_evpage);
endmodule
